FILE: hdl/bdpc_pkg.sv
`timescale 1ns / 1ps

package bdpc_pkg;

    // Counter and register width
    localparam int unsigned CNT_W   = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS   = 2'd0,
        CFG_SHORT_PRESS_MAX  = 2'd1,
        CFG_LONG_PRESS_TICKS = 2'd2
    } t_cfg_idx;

    // Register reset values
    localparam logic [CNT_W-1:0] RST_DEBOUNCE_TICKS   = 16'd15;
    localparam logic [CNT_W-1:0] RST_SHORT_PRESS_MAX  = 16'd1000;
    localparam logic [CNT_W-1:0] RST_LONG_PRESS_TICKS = 16'd3000;

    // Button levels (active low)
    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    // One result request
    typedef struct packed {
        logic stable_level;
        logic press_event;
        logic release_event;
        logic short_press_event;
        logic long_press_event;
    } t_result;

    // Saturating increment of a tick counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
        return r;
    endfunction

endpackage

FILE: hdl/button_debounce_press_classifier_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// --------  ---------  -----------------  ------------------------------------------
// input     in         i_valid / o_stall  i_raw_level
// result    out        o_valid / i_stall  o_stable_level, o_press_event,
//                                         o_release_event, o_short_press_event,
//                                         o_long_press_event
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One request per cycle while the result is not stalled; each request passes the
// input register, then the filter/classifier logic feeding the result register.
// Synchronous active-low reset restores the register defaults (15, 1000, 3000)
// and the released state.
// A stalled result holds the result register; the input register keeps taking
// a request while the result register is free or being drained.
module button_debounce_press_classifier_core
    import bdpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_raw_level,

    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_stable_level,
    output logic                 o_press_event,
    output logic                 o_release_event,
    output logic                 o_short_press_event,
    output logic                 o_long_press_event,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [CNT_W-1:0] r_debounce_ticks;
    logic [CNT_W-1:0] r_short_press_max;
    logic [CNT_W-1:0] r_long_press_ticks;

    // Input stage
    logic r_in_valid;
    logic r_in_raw;

    // Filter / classifier state
    logic             r_filter_level;
    logic             r_debounce_active;
    logic [CNT_W-1:0] r_debounce_count;
    logic             r_accepted_level;
    logic             r_hold_armed;
    logic [CNT_W-1:0] r_hold_count;

    logic             n_filter_level;
    logic             n_debounce_active;
    logic [CNT_W-1:0] n_debounce_count;
    logic             n_accepted_level;
    logic             n_hold_armed;
    logic [CNT_W-1:0] n_hold_count;
    t_result          n_result;

    // Result stage
    logic    r_out_valid;
    t_result r_result;

    logic s1_adv;
    logic out_free;

    // Handshake
    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= RST_DEBOUNCE_TICKS;
            r_short_press_max  <= RST_SHORT_PRESS_MAX;
            r_long_press_ticks <= RST_LONG_PRESS_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE_TICKS:   r_debounce_ticks   <= i_cfg_data;
                CFG_SHORT_PRESS_MAX:  r_short_press_max  <= i_cfg_data;
                CFG_LONG_PRESS_TICKS: r_long_press_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_raw <= i_raw_level;
        end
    end

    // Debounce filter and press classification for the request in the input stage
    always_comb begin
        logic edge_seen;
        logic armed_mid;
        logic [CNT_W-1:0] hold_mid;

        n_filter_level    = r_filter_level;
        n_debounce_active = r_debounce_active;
        n_debounce_count  = r_debounce_count;
        n_accepted_level  = r_accepted_level;
        n_result          = '0;

        // Raw change restarts the count; otherwise count while settling
        if (r_in_raw != r_filter_level) begin
            n_filter_level    = r_in_raw;
            n_debounce_active = 1'b1;
            n_debounce_count  = '0;
        end else if (r_debounce_active) begin
            n_debounce_count = sat_inc(r_debounce_count);
        end
        if (n_debounce_active && (n_debounce_count >= r_debounce_ticks)) begin
            n_accepted_level  = n_filter_level;
            n_debounce_active = 1'b0;
        end

        // Previous level is the accepted level before this request
        edge_seen = (n_accepted_level != r_accepted_level);

        armed_mid = r_hold_armed;
        hold_mid  = r_hold_count;
        if (edge_seen && (n_accepted_level == LVL_PRESSED)) begin
            n_result.press_event = 1'b1;
            armed_mid = 1'b1;
            hold_mid  = '0;
        end else if (r_hold_armed) begin
            hold_mid = sat_inc(r_hold_count);
        end

        n_hold_armed = armed_mid;
        if (edge_seen && (n_accepted_level == LVL_RELEASED)) begin
            n_result.release_event     = 1'b1;
            n_result.short_press_event = armed_mid && (hold_mid <= r_short_press_max);
            n_hold_armed = 1'b0;
        end

        // Long press fires once, then disarms
        if (n_hold_armed && (hold_mid >= r_long_press_ticks)) begin
            n_result.long_press_event = 1'b1;
            n_hold_armed = 1'b0;
        end

        n_hold_count          = hold_mid;
        n_result.stable_level = n_accepted_level;
    end

    // State update on each request that moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_level    <= LVL_RELEASED;
            r_debounce_active <= 1'b0;
            r_debounce_count  <= '0;
            r_accepted_level  <= LVL_RELEASED;
            r_hold_armed      <= 1'b0;
            r_hold_count      <= '0;
        end else if (s1_adv) begin
            r_filter_level    <= n_filter_level;
            r_debounce_active <= n_debounce_active;
            r_debounce_count  <= n_debounce_count;
            r_accepted_level  <= n_accepted_level;
            r_hold_armed      <= n_hold_armed;
            r_hold_count      <= n_hold_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_result <= n_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_stable_level      = r_result.stable_level;
    assign o_press_event       = r_result.press_event;
    assign o_release_event     = r_result.release_event;
    assign o_short_press_event = r_result.short_press_event;
    assign o_long_press_event  = r_result.long_press_event;

endmodule
